@@ rtl/compass_heading_with_offset_cal_defines.svh @@
// ----------------------------------------------------------------------------
// compass_heading_with_offset_cal_defines
// Assertion macros shared by the compass heading RTL.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_WITH_OFFSET_CAL_DEFINES_SVH
`define COMPASS_HEADING_WITH_OFFSET_CAL_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CHWOC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CHWOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/chwoc_pkg.sv @@
// ----------------------------------------------------------------------------
// chwoc_pkg
// Shared widths, codes and the CORDIC arctangent table for the compass block.
// ----------------------------------------------------------------------------
`default_nettype none
package chwoc_pkg;
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int CORDIC_N   = 16;
    localparam int STEP_W     = 5;
    localparam int NORM_BIT   = 40;
    localparam int VEC_W      = NORM_BIT + 4;
    localparam int FRAC_W     = 16;
    localparam int ANG_W      = 26;
    localparam int HEAD_W     = 9;

    typedef enum logic [1:0] {
        OP_HEADING   = 2'd0,
        OP_CAL_FIRST = 2'd1,
        OP_CAL_NEXT  = 2'd2,
        OP_CAL_LAST  = 2'd3
    } t_op;

    localparam logic KIND_HEADING = 1'b0;
    localparam logic KIND_CAL     = 1'b1;

    localparam logic REG_DECL   = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117266;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/chwoc_cal.sv @@
// ----------------------------------------------------------------------------
// chwoc_cal
// Per-axis min/max tracking and hard-iron offset latch.
// ----------------------------------------------------------------------------
`default_nettype none
module chwoc_cal (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_we,
    input  wire logic [1:0]                            i_op,
    input  wire logic signed [chwoc_pkg::SAMPLE_W-1:0] i_s [3],
    input  wire logic [15:0]                           i_thresh,
    output logic signed [chwoc_pkg::SAMPLE_W-1:0]      o_off [3]
);
    localparam int SW = chwoc_pkg::SAMPLE_W;

    logic signed [SW-1:0] r_max [3];
    logic signed [SW-1:0] r_min [3];
    logic signed [SW-1:0] r_off [3];
    logic signed [SW-1:0] n_max [3];
    logic signed [SW-1:0] n_min [3];
    logic signed [SW-1:0] n_off [3];
    logic signed [SW:0]   w_sum [3];
    logic signed [SW:0]   w_half [3];
    logic [SW:0]          w_span [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_op == chwoc_pkg::OP_CAL_FIRST) begin
                n_max[k] = i_s[k];
                n_min[k] = i_s[k];
            end else begin
                n_max[k] = (i_s[k] > r_max[k]) ? i_s[k] : r_max[k];
                n_min[k] = (i_s[k] < r_min[k]) ? i_s[k] : r_min[k];
            end
            w_span[k] = {n_max[k][SW-1], n_max[k]} - {n_min[k][SW-1], n_min[k]};
            w_sum[k]  = {n_max[k][SW-1], n_max[k]} + {n_min[k][SW-1], n_min[k]};
            w_half[k] = (w_sum[k] + {{SW{1'b0}}, w_sum[k][SW] & w_sum[k][0]}) >>> 1;
            n_off[k]  = r_off[k];
            if (i_op == chwoc_pkg::OP_CAL_FIRST) begin
                n_off[k] = '0;
            end else if (i_op == chwoc_pkg::OP_CAL_LAST
                         && w_span[k] > {1'b0, i_thresh}) begin
                n_off[k] = w_half[k][SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_max[k] <= '0;
                r_min[k] <= '0;
                r_off[k] <= '0;
            end
        end else if (i_we && i_op != chwoc_pkg::OP_HEADING) begin
            for (int k = 0; k < 3; k++) begin
                r_max[k] <= n_max[k];
                r_min[k] <= n_min[k];
                r_off[k] <= n_off[k];
            end
        end
    end

    assign o_off = r_off;
endmodule
`default_nettype wire

@@ rtl/chwoc_cordic.sv @@
// ----------------------------------------------------------------------------
// chwoc_cordic
// Iterative vectoring CORDIC giving atan2 in whole degrees, 0 to 359.
// ----------------------------------------------------------------------------
`default_nettype none
module chwoc_cordic (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [chwoc_pkg::DIFF_W-1:0] i_dx,
    input  wire logic signed [chwoc_pkg::DIFF_W-1:0] i_dy,
    output logic                                     o_done,
    output logic [chwoc_pkg::HEAD_W-1:0]             o_angle
);
    localparam int DW = chwoc_pkg::DIFF_W;
    localparam int VW = chwoc_pkg::VEC_W;
    localparam int AW = chwoc_pkg::ANG_W;
    localparam logic signed [AW-1:0] DEG90  = AW'(90)  <<< chwoc_pkg::FRAC_W;
    localparam logic signed [AW-1:0] DEG180 = AW'(180) <<< chwoc_pkg::FRAC_W;
    localparam logic signed [AW-1:0] DEG360 = AW'(360) <<< chwoc_pkg::FRAC_W;

    logic signed [VW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic [chwoc_pkg::STEP_W-1:0] r_i;
    logic r_run, r_done, r_nx, r_ny;

    logic [DW-1:0] w_ax, w_ay, w_m;
    logic [5:0] w_msb, w_sh;
    logic signed [VW-1:0] w_xs, w_ys;
    logic signed [AW-1:0] w_a, w_ang;

    always_comb begin
        w_ax  = i_dx[DW-1] ? DW'(-i_dx) : DW'(i_dx);
        w_ay  = i_dy[DW-1] ? DW'(-i_dy) : DW'(i_dy);
        w_m   = (w_ax > w_ay) ? w_ax : w_ay;
        w_msb = '0;
        for (int b = 0; b < DW; b++) begin
            if (w_m[b]) begin
                w_msb = 6'(b);
            end
        end
        w_sh = 6'(chwoc_pkg::NORM_BIT) - w_msb;
        w_xs = r_x >>> r_i;
        w_ys = r_y >>> r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_nx <= i_dx[DW-1];
                r_ny <= i_dy[DW-1];
                r_i  <= '0;
                r_x  <= VW'(w_ax) <<< w_sh;
                r_y  <= VW'(w_ay) <<< w_sh;
                if (w_ay == '0) begin
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else if (w_ax == '0) begin
                    r_z    <= DEG90;
                    r_done <= 1'b1;
                end else begin
                    r_z   <= '0;
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                if (r_y > 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + chwoc_pkg::atan_deg(r_i);
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - chwoc_pkg::atan_deg(r_i);
                end
                r_i <= r_i + 1'b1;
                if (r_i == chwoc_pkg::STEP_W'(chwoc_pkg::CORDIC_N - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_a = r_z;
        if (w_a < 0) begin
            w_a = '0;
        end
        if (w_a > DEG90) begin
            w_a = DEG90;
        end
        if (!r_nx && !r_ny) begin
            w_ang = w_a;
        end else if (r_nx && !r_ny) begin
            w_ang = DEG180 - w_a;
        end else if (r_nx) begin
            w_ang = DEG180 + w_a;
        end else begin
            w_ang = DEG360 - w_a;
        end
        if (w_ang >= DEG360) begin
            w_ang = w_ang - DEG360;
        end
    end

    assign o_done  = r_done;
    assign o_angle = w_ang[chwoc_pkg::FRAC_W +: chwoc_pkg::HEAD_W];
endmodule
`default_nettype wire

@@ rtl/compass_heading_with_offset_cal.sv @@
// A heading request is accepted in idle and runs 16 iterations of the CORDIC unit; the angle is
// then taken in the CORDIC state, and the result word is loaded in the finish state.
// A zero axis skips the iterations and goes straight on to taking the angle and the finish state.
// A calibration sample is taken on acceptance; the last one then goes to the finish state for its result word.
// One item is in work at a time: requests are accepted only in idle, and finish waits for the output to be free.
// Synchronous active-low reset clears offsets, min/max, registers and control.
// ----------------------------------------------------------------------------
// compass_heading_with_offset_cal
// Hard-iron calibration and atan2 compass heading with declination.
// ----------------------------------------------------------------------------
`default_nettype none
`include "compass_heading_with_offset_cal_defines.svh"
module compass_heading_with_offset_cal (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // mag_x, mag_y, mag_z
    input  wire logic [1:0]  s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // heading_deg, offset_x, offset_y, offset_z, zero pad
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tuser,  // result_kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int SW = chwoc_pkg::SAMPLE_W;
    localparam int HW = chwoc_pkg::HEAD_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CORD = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state r_state;
    logic signed [7:0] r_decl;
    logic [15:0] r_thresh;
    logic r_kind, r_ovalid, r_okind;
    logic [HW-1:0] r_ang, r_ohead;
    logic signed [SW-1:0] r_oo [3];

    logic w_acc, w_cfg_we, w_load, w_done;
    logic signed [SW-1:0] w_s [3];
    logic signed [SW-1:0] w_off [3];
    logic signed [chwoc_pkg::DIFF_W-1:0] w_dx, w_dy;
    logic [HW-1:0] w_angle;
    logic signed [10:0] w_h;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_cfg_we      = psel && penable && pwrite && pready;
    assign w_load        = (r_state == ST_FIN) && (!r_ovalid || m_axis_tready);

    assign w_s[0] = s_axis_tdata[0 +: SW];
    assign w_s[1] = s_axis_tdata[SW +: SW];
    assign w_s[2] = s_axis_tdata[2*SW +: SW];
    assign w_dx = {w_s[0][SW-1], w_s[0]} - {w_off[0][SW-1], w_off[0]};
    assign w_dy = {w_s[1][SW-1], w_s[1]} - {w_off[1][SW-1], w_off[1]};

    chwoc_cal u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_acc),
        .i_op     (s_axis_tuser),
        .i_s      (w_s),
        .i_thresh (r_thresh),
        .o_off    (w_off)
    );

    chwoc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc && s_axis_tuser == chwoc_pkg::OP_HEADING),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_done  (w_done),
        .o_angle (w_angle)
    );

    always_comb begin
        w_h = 11'(r_ang) + 11'(r_decl);
        if (w_h > 11'sd360) begin
            w_h = w_h - 11'sd360;
        end
        if (w_h < 0) begin
            w_h = w_h + 11'sd360;
        end
    end

    always_comb begin
        case (paddr[2])
            chwoc_pkg::REG_DECL: prdata = {24'd0, r_decl};
            default:             prdata = {16'd0, r_thresh};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_decl   <= '0;
            r_thresh <= '0;
            r_ovalid <= 1'b0;
            r_kind   <= chwoc_pkg::KIND_HEADING;
        end else begin
            if (w_cfg_we) begin
                case (paddr[2])
                    chwoc_pkg::REG_DECL: r_decl   <= pwdata[7:0];
                    default:             r_thresh <= pwdata[15:0];
                endcase
            end
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && s_axis_tuser == chwoc_pkg::OP_HEADING) begin
                        r_kind  <= chwoc_pkg::KIND_HEADING;
                        r_state <= ST_CORD;
                    end else if (w_acc && s_axis_tuser == chwoc_pkg::OP_CAL_LAST) begin
                        r_kind  <= chwoc_pkg::KIND_CAL;
                        r_ang   <= '0;
                        r_state <= ST_FIN;
                    end
                end
                ST_CORD: begin
                    if (w_done) begin
                        r_ang   <= w_angle;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_load) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_kind;
                        r_ohead  <= (r_kind == chwoc_pkg::KIND_CAL) ? '0 : w_h[HW-1:0];
                        r_oo     <= w_off;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {7'd0, r_oo[2], r_oo[1], r_oo[0], r_ohead};

    `CHWOC_ASSERT_NOW(a_done_in_cord, w_done, r_state == ST_CORD,
        "CORDIC done outside CORDIC state")
    `CHWOC_ASSERT_NEXT(a_fin_loads, w_load, m_axis_tvalid && r_state == ST_IDLE,
        "finish did not load output")
    `CHWOC_ASSERT_NEXT(a_cal_clears, w_acc && s_axis_tuser == chwoc_pkg::OP_CAL_FIRST,
        w_off[0] == '0 && w_off[1] == '0 && w_off[2] == '0,
        "calibration start left offsets")
endmodule
`default_nettype wire
